// File: hw/rtl/htm_pkg.sv
// Shared types and constants for the heightmap to mesh block.
`default_nettype none
package htm_pkg;
    localparam int MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int IDX_W = 23;

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_STEP_X = 3'd2;
    localparam logic [2:0] CFG_STEP_Y = 3'd3;
    localparam logic [2:0] CFG_HSTEP  = 3'd4;
    localparam logic [2:0] CFG_TEX_U  = 3'd5;
    localparam logic [2:0] CFG_TEX_V  = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_PQC, S_SHIFT0, S_MUL, S_SHIFT1, S_SQ, S_SQRT,
        S_DIV, S_NEXT, S_EMIT
    } t_state;

    // controller commands into the datapath
    typedef struct packed {
        logic load;      // capture the item, read line buffer
        logic pqc;       // form P, Q, C (one product a cycle)
        logic shift0;    // one step of first normalizing shift
        logic mul;       // component products
        logic shift1;    // one step of second normalizing shift
        logic sq;        // squares and sum
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic face2;     // switch to second face
        logic emit_next; // advance vertex
        logic finish;    // update line buffer and counters
    } t_cmd;

    typedef struct packed {
        logic quad;      // item completes a cell
        logic pqc_done;
        logic shift0_done;
        logic shift1_done;
        logic sq_done;
        logic sqrt_done;
        logic div_done;
        logic face1;
        logic last_vertex;
    } t_status;
endpackage
`default_nettype wire

// File: hw/rtl/htm_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module htm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/htm_ctrl.sv
// Sequencer for one heightmap item: normal pipeline steps and vertex emission.
`default_nettype none
module htm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire htm_pkg::t_status i_st,
    output htm_pkg::t_cmd       o_cmd
);
    import htm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_READ;
            S_READ:   n_state = i_st.quad ? S_PQC : S_NEXT;
            S_PQC:    if (i_st.pqc_done) n_state = S_SHIFT0;
            S_SHIFT0: if (i_st.shift0_done) n_state = S_MUL;
            S_MUL:    n_state = S_SHIFT1;
            S_SHIFT1: if (i_st.shift1_done) n_state = S_SQ;
            S_SQ:     if (i_st.sq_done) n_state = S_SQRT;
            S_SQRT:   if (i_st.sqrt_done) n_state = S_DIV;
            S_DIV: begin
                if (i_st.div_done) n_state = i_st.face1 ? S_SHIFT0 : S_EMIT;
            end
            S_EMIT:   if (i_out_ready && i_st.last_vertex) n_state = S_NEXT;
            S_NEXT:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_READ:   o_cmd.pqc = i_st.quad;
            S_PQC:    o_cmd.pqc = 1'b1;
            S_SHIFT0: o_cmd.shift0 = 1'b1;
            S_MUL:    o_cmd.mul = 1'b1;
            S_SHIFT1: o_cmd.shift1 = 1'b1;
            S_SQ: begin
                o_cmd.sq = 1'b1;
                o_cmd.sqrt_init = i_st.sq_done;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                o_cmd.div_init = i_st.sqrt_done;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.face2 = i_st.div_done && i_st.face1;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.emit_next = i_out_ready;
            end
            S_NEXT:   o_cmd.finish = 1'b1;
            default:  ;
        endcase
    end
endmodule
`default_nettype wire

// File: hw/rtl/htm_datapath.sv
// Datapath: counters, line buffer, normal computation and vertex fields.
`default_nettype none
module htm_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_addr,
    input  wire logic [31:0]   i_cfg_wdata,
    input  wire logic [7:0]    i_height_sample,
    input  wire logic          i_start_of_map,
    input  wire htm_pkg::t_cmd i_cmd,
    output htm_pkg::t_status   o_st,
    output logic [31:0]        o_pos_x,
    output logic [31:0]        o_pos_y,
    output logic [31:0]        o_pos_z,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic [14:0]        o_normal_z,
    output logic [15:0]        o_tex_u,
    output logic [15:0]        o_tex_v,
    output logic [22:0]        o_vertex_index,
    output logic               o_last_of_run
);
    import htm_pkg::*;

    // configuration registers
    logic [10:0] r_width, r_height;
    logic [31:0] r_sx, r_sy, r_hs;
    logic [15:0] r_tu, r_tv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 11'd2; r_height <= 11'd2;
            r_sx <= 32'd65536; r_sy <= 32'd65536; r_hs <= 32'd257;
            r_tu <= 16'd32768; r_tv <= 16'd32768;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WIDTH:  r_width <= i_cfg_wdata[10:0];
                CFG_HEIGHT: r_height <= i_cfg_wdata[10:0];
                CFG_STEP_X: r_sx <= i_cfg_wdata;
                CFG_STEP_Y: r_sy <= i_cfg_wdata;
                CFG_HSTEP:  r_hs <= i_cfg_wdata;
                CFG_TEX_U:  r_tu <= i_cfg_wdata[15:0];
                CFG_TEX_V:  r_tv <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // clamped geometry
    logic [11:0] w_eff, h_eff;
    always_comb begin
        w_eff = (r_width < 11'd2) ? 12'd2 :
                (r_width > 11'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : {1'b0, r_width};
        h_eff = (r_height < 11'd2) ? 12'd2 :
                (r_height > 11'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : {1'b0, r_height};
    end

    // position counters and left heights
    logic [COL_W-1:0] r_col, r_colw;
    logic [ROW_W-1:0] r_row, r_roww;
    logic [IDX_W-1:0] r_idx;
    logic [7:0] r_left_cur, r_left_prev, r_h;
    logic [7:0] w_above;
    logic [COL_W-1:0] w_col;
    logic [ROW_W-1:0] w_row;
    logic [COL_W-1:0] w_raddr;

    assign w_col = i_start_of_map ? '0 : r_col;
    assign w_row = i_start_of_map ? '0 : r_row;
    // keep reading the captured column so the above height stays put
    assign w_raddr = i_cmd.load ? w_col : r_colw;

    htm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line (
        .i_clk(i_clk),
        .i_we(i_cmd.finish),
        .i_waddr(r_colw),
        .i_wdata(r_h),
        .i_raddr(w_raddr),
        .o_rdata(w_above)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0; r_row <= '0; r_idx <= '0;
            r_left_cur <= '0; r_left_prev <= '0;
        end else begin
            if (i_cmd.load && i_start_of_map) r_idx <= '0;
            if (i_cmd.emit_next) r_idx <= r_idx + 1'b1;
            if (i_cmd.finish) begin
                r_left_prev <= w_above;
                r_left_cur <= r_h;
                if ({1'b0, r_colw} + 12'd1 >= w_eff) begin
                    r_col <= '0;
                    r_row <= ({1'b0, r_roww} + 12'd1 >= h_eff) ? '0 : r_roww + 1'b1;
                end else begin
                    r_col <= r_colw + 1'b1;
                    r_row <= r_roww;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_h <= i_height_sample;
            r_colw <= w_col;
            r_roww <= w_row;
        end
    end

    // height differences for current face
    logic r_face1;
    logic signed [8:0] w_dx, w_dy;
    always_comb begin
        if (r_face1) begin
            w_dx = $signed({1'b0, r_left_prev}) - $signed({1'b0, w_above});
            w_dy = $signed({1'b0, r_left_prev}) - $signed({1'b0, r_left_cur});
        end else begin
            w_dx = $signed({1'b0, r_left_cur}) - $signed({1'b0, r_h});
            w_dy = $signed({1'b0, w_above}) - $signed({1'b0, r_h});
        end
    end
    logic [7:0] w_adx, w_ady;
    assign w_adx = w_dx[8] ? 8'(-w_dx) : w_dx[7:0];
    assign w_ady = w_dy[8] ? 8'(-w_dy) : w_dy[7:0];

    // P, Q, C: one 32x32 product per cycle
    logic [1:0]  r_pqc_cnt;
    logic [63:0] r_p, r_q, r_c, r_pq, r_qq, r_cq;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    always_comb begin
        case (r_pqc_cnt)
            2'd0: begin w_ma = r_hs; w_mb = r_sy; end
            2'd1: begin w_ma = r_hs; w_mb = r_sx; end
            default: begin w_ma = r_sx; w_mb = r_sy; end
        endcase
    end
    assign w_prod = 64'(w_ma) * 64'(w_mb);

    // first shift: one bit a cycle until all below 2^56
    logic w_big0;
    assign w_big0 = (r_pq[63:56] != '0) || (r_qq[63:56] != '0) || (r_cq[63:56] != '0);

    // component products, 8-bit by 56-bit
    logic [63:0] r_a, r_b, r_cc;
    logic w_big1;
    assign w_big1 = (r_a[63:31] != '0) || (r_b[63:31] != '0) || (r_cc[63:31] != '0);

    // squares: one 31x31 square per cycle, accumulated
    logic [1:0]  r_sq_cnt;
    logic [63:0] r_sum;
    logic [30:0] w_sq_in;
    always_comb begin
        case (r_sq_cnt)
            2'd0: w_sq_in = r_a[30:0];
            2'd1: w_sq_in = r_b[30:0];
            default: w_sq_in = r_cc[30:0];
        endcase
    end

    // bit-pair square root, one step a cycle
    logic [63:0] r_rem, r_root, r_bit;
    logic [63:0] w_trial;
    assign w_trial = r_root + r_bit;

    // restoring divider shared by three components, one quotient bit a cycle
    logic [1:0]  r_div_sel;
    logic [5:0]  r_div_cnt;
    logic [45:0] r_num, r_quo;
    logic [32:0] r_drem;
    logic [31:0] r_len;
    logic [33:0] w_drem_sh;
    logic [45:0] w_num0;
    logic [14:0] r_n1x, r_n1y, r_n1z, r_n2x, r_n2y, r_n2z;
    logic r_s1x, r_s1y, r_s2x, r_s2y;
    // x component goes first
    assign w_num0 = {1'b0, r_a[30:0], 14'd0} + 46'(r_root[31:1]);
    assign w_drem_sh = {r_drem, r_num[45]};

    logic [14:0] w_qres;
    assign w_qres = r_quo[14:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face1 <= 1'b1;
        end else begin
            if (i_cmd.load) r_face1 <= 1'b1;
            if (i_cmd.face2) r_face1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_pqc_cnt <= '0;
        if (i_cmd.pqc) begin
            r_pqc_cnt <= r_pqc_cnt + 1'b1;
            case (r_pqc_cnt)
                2'd0: r_p <= w_prod;
                2'd1: r_q <= w_prod;
                default: r_c <= w_prod;
            endcase
        end
        if (o_st.pqc_done && i_cmd.pqc) begin
            r_pq <= r_p; r_qq <= r_q; r_cq <= w_prod;
        end
        if (i_cmd.face2) begin
            r_pq <= r_p; r_qq <= r_q; r_cq <= r_c;
        end
        if (i_cmd.shift0 && w_big0) begin
            r_pq <= r_pq >> 1; r_qq <= r_qq >> 1; r_cq <= r_cq >> 1;
        end
        if (i_cmd.mul) begin
            r_a <= 64'(w_adx) * r_pq;
            r_b <= 64'(w_ady) * r_qq;
            r_cc <= r_cq;
            r_sq_cnt <= '0;
            r_sum <= '0;
        end
        if (i_cmd.shift1 && w_big1) begin
            r_a <= r_a >> 1; r_b <= r_b >> 1; r_cc <= r_cc >> 1;
        end
        if (i_cmd.sq && !o_st.sq_done) begin
            r_sum <= r_sum + 64'(w_sq_in) * 64'(w_sq_in);
            r_sq_cnt <= r_sq_cnt + 1'b1;
        end
        if (i_cmd.sqrt_init) begin
            r_rem <= r_sum; r_root <= '0; r_bit <= 64'd1 << 62;
        end
        if (i_cmd.sqrt_step && !o_st.sqrt_done) begin
            if (r_rem >= w_trial) begin
                r_rem <= r_rem - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_init) begin
            r_div_sel <= '0; r_div_cnt <= '0;
            r_len <= r_root[31:0];
            r_num <= w_num0; r_drem <= '0; r_quo <= '0;
        end
        if (i_cmd.div_step && !o_st.div_done) begin
            if (r_div_cnt == 6'd46) begin
                // store result, start next component
                if (r_face1) begin
                    case (r_div_sel)
                        2'd0: begin r_n1x <= w_qres; r_s1x <= w_dx[8]; end
                        2'd1: begin r_n1y <= w_qres; r_s1y <= w_dy[8]; end
                        default: r_n1z <= w_qres;
                    endcase
                end else begin
                    case (r_div_sel)
                        2'd0: begin r_n2x <= w_qres; r_s2x <= w_dx[8]; end
                        2'd1: begin r_n2y <= w_qres; r_s2y <= w_dy[8]; end
                        default: r_n2z <= w_qres;
                    endcase
                end
                r_div_sel <= r_div_sel + 1'b1;
                r_div_cnt <= '0;
                r_drem <= '0; r_quo <= '0;
                r_num <= {1'b0, (r_div_sel == 2'd0) ? r_b[30:0] : r_cc[30:0], 14'd0}
                         + 46'(r_len[31:1]);
            end else begin
                r_num <= r_num << 1;
                if (w_drem_sh >= {2'b0, r_len}) begin
                    r_drem <= 33'(w_drem_sh - {2'b0, r_len});
                    r_quo <= {r_quo[44:0], 1'b1};
                end else begin
                    r_drem <= w_drem_sh[32:0];
                    r_quo <= {r_quo[44:0], 1'b0};
                end
                r_div_cnt <= r_div_cnt + 1'b1;
            end
        end
        // a zero length gives the straight-up normal
        if (i_cmd.div_step && o_st.div_done && r_len == '0) begin
            if (r_face1) begin
                r_n1x <= '0; r_n1y <= '0; r_n1z <= 15'd16384; r_s1x <= 1'b0; r_s1y <= 1'b0;
            end else begin
                r_n2x <= '0; r_n2y <= '0; r_n2z <= 15'd16384; r_s2x <= 1'b0; r_s2y <= 1'b0;
            end
        end
    end

    // vertex sequencing
    logic [2:0] r_vtx;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_vtx <= '0;
        else if (i_cmd.emit_next) r_vtx <= r_vtx + 1'b1;
    end

    always_comb begin
        o_st.quad = (r_colw != '0) && (r_roww != '0);
        o_st.pqc_done = (r_pqc_cnt == 2'd2);
        o_st.shift0_done = !w_big0;
        o_st.shift1_done = !w_big1;
        o_st.sq_done = (r_sq_cnt == 2'd3);
        o_st.sqrt_done = (r_bit == '0);
        o_st.div_done = (r_div_sel == 2'd3) || (r_len == '0);
        o_st.face1 = r_face1;
        o_st.last_vertex = (r_vtx == 3'd5);
    end

    // corner for each vertex: bl, br, tl, tl, br, tr
    logic w_cx1, w_cy1;
    logic [7:0] w_hv;
    always_comb begin
        case (r_vtx)
            3'd0: begin w_cx1 = 1'b0; w_cy1 = 1'b0; w_hv = r_left_prev; end
            3'd1, 3'd4: begin w_cx1 = 1'b1; w_cy1 = 1'b0; w_hv = w_above; end
            3'd2, 3'd3: begin w_cx1 = 1'b0; w_cy1 = 1'b1; w_hv = r_left_cur; end
            default: begin w_cx1 = 1'b1; w_cy1 = 1'b1; w_hv = r_h; end
        endcase
    end

    logic [COL_W-1:0] w_cx;
    logic [ROW_W-1:0] w_cy;
    assign w_cx = w_cx1 ? r_colw : r_colw - 1'b1;
    assign w_cy = w_cy1 ? r_roww : r_roww - 1'b1;

    logic [41:0] w_px, w_py;
    logic [39:0] w_pz;
    logic [27:0] w_tu, w_tv;
    assign w_px = 42'(w_cx) * 42'(r_sx);
    assign w_py = 42'(w_cy) * 42'(r_sy);
    assign w_pz = 40'(w_hv) * 40'(r_hs);
    assign w_tu = 28'(r_tu) * 28'({w_cx, 1'b1});
    assign w_tv = 28'(r_tv) * 28'({w_cy, 1'b1});

    logic w_f1;
    assign w_f1 = (r_vtx < 3'd3);
    always_comb begin
        o_pos_x = (w_px[41:32] != '0) ? '1 : w_px[31:0];
        o_pos_y = (w_py[41:32] != '0) ? '1 : w_py[31:0];
        o_pos_z = (w_pz[39:32] != '0) ? '1 : w_pz[31:0];
        o_tex_u = (w_tu[27:17] != '0) ? '1 : w_tu[16:1];
        o_tex_v = (w_tv[27:17] != '0) ? '1 : w_tv[16:1];
        if (w_f1) begin
            o_normal_x = r_s1x ? -$signed({1'b0, r_n1x}) : $signed({1'b0, r_n1x});
            o_normal_y = r_s1y ? -$signed({1'b0, r_n1y}) : $signed({1'b0, r_n1y});
            o_normal_z = r_n1z;
        end else begin
            o_normal_x = r_s2x ? -$signed({1'b0, r_n2x}) : $signed({1'b0, r_n2x});
            o_normal_y = r_s2y ? -$signed({1'b0, r_n2y}) : $signed({1'b0, r_n2y});
            o_normal_z = r_n2z;
        end
        o_vertex_index = r_idx;
        o_last_of_run = (r_vtx == 3'd5);
    end
endmodule
`default_nettype wire

// File: hw/rtl/heightmap_to_triangle_mesh.sv
// Top level of the heightmap to triangle mesh block.
// Usage: heightmap samples enter on the i_in_valid/o_in_ready channel in raster
// order, bottom row first; i_start_of_map on the first sample restarts the
// column, row and vertex index. Every sample with column and row above zero
// completes a grid cell and yields six vertices on o_out_valid/i_out_ready:
// bl, br, tl with the first face normal, then tl, br, tr with the second.
// Other samples yield nothing; they pass the read and finish states before the
// next sample is taken. A cell sample computes both face normals before its
// first vertex; a zero-length normal skips the divider. Each face normal passes
// two bit-at-a-time shifters, a 32-step square root and a shared divider doing
// three 46-bit quotients, one bit a cycle. Vertices then leave one per cycle
// while the receiver takes them; a stall holds the vertex. The finish state
// follows the last vertex before the next sample is taken.
// One sample is processed at a time. Configuration is written through i_cfg_we/
// i_cfg_addr/i_cfg_wdata; the user must do so only while idle (not enforced).
// After synchronous reset the registers hold their defaults and position and index
// counters are zero; the line buffer holds nothing until a row has been written.
`default_nettype none
module heightmap_to_triangle_mesh (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_height_sample,
    input  wire logic        i_start_of_map,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_pos_x,
    output logic [31:0]      o_pos_y,
    output logic [31:0]      o_pos_z,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic [14:0]      o_normal_z,
    output logic [15:0]      o_tex_u,
    output logic [15:0]      o_tex_v,
    output logic [22:0]      o_vertex_index,
    output logic             o_last_of_run
);
    import htm_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;

    htm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_st(w_st), .o_cmd(w_cmd)
    );

    htm_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .i_height_sample(i_height_sample), .i_start_of_map(i_start_of_map),
        .i_cmd(w_cmd), .o_st(w_st),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_tex_u(o_tex_u), .o_tex_v(o_tex_v),
        .o_vertex_index(o_vertex_index), .o_last_of_run(o_last_of_run)
    );
endmodule
`default_nettype wire

// File: hw/rtl/htm_checker.sv
// Port-level checks for the heightmap to mesh block, bound to the top level.
`default_nettype none
module htm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_last_of_run,
    input wire logic [22:0] o_vertex_index,
    input wire logic [14:0] o_normal_z
);
    // no new item is taken while vertices are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("input taken during emission");

    // a stalled vertex holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_vertex_index))
        else $error("stalled vertex changed");

    // index advances by one inside a run
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_of_run |=>
        o_out_valid && o_vertex_index == $past(o_vertex_index) + 23'd1)
        else $error("vertex index skipped");

    // normal z never exceeds one
    a_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_normal_z <= 15'd16384) else $error("normal z out of range");
endmodule

bind heightmap_to_triangle_mesh htm_checker u_htm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_last_of_run(o_last_of_run), .o_vertex_index(o_vertex_index),
    .o_normal_z(o_normal_z)
);
`default_nettype wire
